// File: rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants, types and helper functions for the peak pair hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  // Pairing window and field widths.
  localparam int FAN        = 11;
  localparam int HOLD       = FAN - 1;
  localparam int FREQ_BITS  = 12;
  localparam int TIME_BITS  = 16;
  localparam int IDX_W      = $clog2(FAN + 1);
  localparam int CFG_IDX_W  = 8;

  // Decimal conversion: a 16-bit value has at most five digits.
  localparam int BIN_W      = 16;
  localparam int DIGITS     = 5;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int DIG_W      = 3;
  localparam int STEP_W     = 4;

  // Message buffer: at most 15 text bytes fit in one padded block.
  localparam int MSG_BYTES  = 16;
  localparam int LEN_W      = 4;

  // SHA-1 round control.
  localparam int ROUNDS     = 80;
  localparam int ROUND_W    = 7;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELTA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA = 8'd1;

  // Text fields of one pair message.
  localparam logic [1:0] FIELD_ANCHOR  = 2'd0;
  localparam logic [1:0] FIELD_PARTNER = 2'd1;
  localparam logic [1:0] FIELD_DELTA   = 2'd2;

  // Window fill count updates.
  localparam logic [1:0] FILL_KEEP  = 2'd0;
  localparam logic [1:0] FILL_INC   = 2'd1;
  localparam logic [1:0] FILL_CLEAR = 2'd2;
  localparam logic [1:0] FILL_HOLD  = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_BAR  = 8'h7C;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load_item;
    logic                 shift_win;
    logic [1:0]           fill_op;
    logic [IDX_W-1:0]     b_idx;
    logic                 msg_clear;
    logic                 bcd_load;
    logic [1:0]           field;
    logic                 bcd_step;
    logic                 emit_digit;
    logic                 emit_bar;
    logic                 sha_init;
    logic                 sha_round;
    logic [ROUND_W-1:0]   round;
    logic                 sha_final;
    logic                 out_load;
    logic                 out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [IDX_W-1:0] fill;
    logic             delta_ok;
    logic             dig_last;
    logic             pend_valid;
    logic             out_full;
  } dp_stat_t;

  // Round constant of SHA-1.
  function automatic logic [31:0] sha_k(input logic [ROUND_W-1:0] r);
    logic [31:0] k;
    if (r < 7'd20)      k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else                k = 32'hCA62C1D6;
    return k;
  endfunction

  // Round function of SHA-1.
  function automatic logic [31:0] sha_f(input logic [ROUND_W-1:0] r,
                                        input logic [31:0] b,
                                        input logic [31:0] c,
                                        input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20)      f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction

endpackage

`default_nettype wire

// File: rtl/peak_pair_sha1_hasher.sv
// ----------------------------------------------------------------------------
// peak_pair_sha1_hasher
// Pairs each anchor peak with its following peaks and emits the SHA-1 of the
// text "freq1|freq2|delta" for every pair inside the time difference bounds.
//
//   Channel  Direction  Word
//   s_axis   in         one peak: frequency, time; tlast ends the track
//   m_axis   out        one digest with the anchor time; tlast ends the run
//   cfg      in         register write: index and 16-bit value
//
// A kept pair takes three decimal conversions, each of one load, 16 shift
// steps and five digit steps, two separator writes, then a setup step,
// 80 SHA-1 rounds of the single round engine and a final step.
// A new peak is taken only once all pair work and any flush for the last
// one are done; a kept pair waits while the output and pending are full.
// Reset is synchronous and clears the window fill count and all control state.
// A stalled output holds one word in the output register and one pending.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_pair_sha1_hasher (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // peak_freq, peak_time
  input  wire logic                          s_axis_tlast,  // final_peak
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // digest_w0, digest_w1, digest_w2, digest_w3, digest_w4, anchor_time
  output logic [175:0]                       m_axis_tdata,
  output logic                               m_axis_tlast,  // run_end
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pps_pkg::TIME_BITS-1:0] cfg_data
);

  pps_pkg::dp_cmd_t  cmd;
  pps_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Window, text builder and hash engine.
  pps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_freq   (s_axis_tdata[pps_pkg::FREQ_BITS-1:0]),
    .in_time   (s_axis_tdata[pps_pkg::FREQ_BITS +: pps_pkg::TIME_BITS]),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  // No digest is left pending while a new peak can be taken.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !stat.pend_valid)
    else $error("digest pending while idle");

  // The window never holds more than FAN-1 peaks between items.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stat.fill <= pps_pkg::IDX_W'(pps_pkg::HOLD))
    else $error("window overfilled");

  // The output register is loaded only when it is free.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !m_axis_tvalid)
    else $error("output register overwritten");

  // A finished digest never overwrites an unsent one.
  a_pend_free: assert property (@(posedge clk) disable iff (rst)
    cmd.sha_final |-> !stat.pend_valid)
    else $error("pending digest overwritten");
`endif

endmodule

`default_nettype wire

// File: rtl/pps_dp.sv
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: peak window, delta check, decimal text builder, SHA-1 round
// engine, pending digest and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pps_pkg::dp_cmd_t              cmd,
  output pps_pkg::dp_stat_t                  stat,
  input  wire logic [pps_pkg::FREQ_BITS-1:0] in_freq,
  input  wire logic [pps_pkg::TIME_BITS-1:0] in_time,
  input  wire logic                          cfg_valid,
  input  wire logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pps_pkg::TIME_BITS-1:0] cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [175:0]                       out_data,
  output logic                               out_last
);

  logic [pps_pkg::FREQ_BITS-1:0] wf [pps_pkg::FAN];
  logic [pps_pkg::TIME_BITS-1:0] wt [pps_pkg::FAN];
  logic [pps_pkg::IDX_W-1:0]     fill;
  logic [pps_pkg::TIME_BITS-1:0] min_delta;
  logic [pps_pkg::TIME_BITS-1:0] max_delta;

  logic [pps_pkg::FREQ_BITS-1:0] part_freq;
  logic [pps_pkg::TIME_BITS-1:0] part_time;
  logic [pps_pkg::TIME_BITS:0]   delta;

  logic [pps_pkg::BIN_W-1:0]     bin;
  logic [pps_pkg::BCD_W-1:0]     bcd;
  logic [pps_pkg::BCD_W-1:0]     bcd_adj;
  logic [pps_pkg::DIG_W-1:0]     dig_idx;
  logic                          seen;
  logic [3:0]                    digit;
  logic [pps_pkg::BIN_W-1:0]     field_val;

  logic [7:0]                    msg [pps_pkg::MSG_BYTES];
  logic [pps_pkg::LEN_W-1:0]     len;
  logic [7:0]                    blk [pps_pkg::MSG_BYTES];

  logic [31:0] w [16];
  logic [31:0] ra, rb, rc, rd, re;
  logic [31:0] tmp;
  logic [31:0] w_new;
  logic [159:0] pend;
  logic [pps_pkg::TIME_BITS-1:0] pend_time;
  logic pend_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_delta <= '0;
      max_delta <= 16'd200;
    end else if (cfg_valid) begin
      if (cfg_index == pps_pkg::REG_MIN_DELTA) min_delta <= cfg_data;
      else if (cfg_index == pps_pkg::REG_MAX_DELTA) max_delta <= cfg_data;
    end
  end

  // Peak window; the anchor always sits in slot zero.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      wf[fill] <= in_freq;
      wt[fill] <= in_time;
    end else if (cmd.shift_win) begin
      for (int i = 0; i < pps_pkg::FAN - 1; i++) begin
        wf[i] <= wf[i+1];
        wt[i] <= wt[i+1];
      end
    end
  end

  // Fill count of held peaks.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      case (cmd.fill_op)
        pps_pkg::FILL_INC:   fill <= fill + 1'b1;
        pps_pkg::FILL_CLEAR: fill <= '0;
        pps_pkg::FILL_HOLD:  fill <= pps_pkg::IDX_W'(pps_pkg::HOLD);
        default:             fill <= fill;
      endcase
    end
  end

  // Partner read and time difference check.
  always_comb begin
    part_freq = '0;
    part_time = '0;
    if (cmd.b_idx < pps_pkg::IDX_W'(pps_pkg::FAN)) begin
      part_freq = wf[cmd.b_idx[pps_pkg::IDX_W-1:0]];
      part_time = wt[cmd.b_idx[pps_pkg::IDX_W-1:0]];
    end
    delta = {1'b0, part_time} - {1'b0, wt[0]};
  end

  // Value of the text field being converted.
  always_comb begin
    case (cmd.field)
      pps_pkg::FIELD_ANCHOR:  field_val = pps_pkg::BIN_W'(wf[0]);
      pps_pkg::FIELD_PARTNER: field_val = pps_pkg::BIN_W'(part_freq);
      default:                field_val = delta[pps_pkg::TIME_BITS-1:0];
    endcase
  end

  // Shift-and-add-three correction of each decimal digit.
  always_comb begin
    for (int i = 0; i < pps_pkg::DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3
                                                   : bcd[4*i +: 4];
    end
    digit = bcd[4*dig_idx +: 4];
  end

  // Binary to decimal conversion and digit output into the message.
  always_ff @(posedge clk) begin
    if (cmd.bcd_load) begin
      bin     <= field_val;
      bcd     <= '0;
      dig_idx <= pps_pkg::DIG_W'(pps_pkg::DIGITS - 1);
      seen    <= 1'b0;
    end else if (cmd.bcd_step) begin
      {bcd, bin} <= {bcd_adj[pps_pkg::BCD_W-2:0], bin, 1'b0};
    end else if (cmd.emit_digit) begin
      dig_idx <= dig_idx - 1'b1;
      if (digit != 4'd0 || seen || dig_idx == '0) begin
        seen     <= 1'b1;
        msg[len] <= pps_pkg::CHAR_ZERO | {4'd0, digit};
        len      <= len + 1'b1;
      end
    end else if (cmd.emit_bar) begin
      msg[len] <= pps_pkg::CHAR_BAR;
      len      <= len + 1'b1;
    end
    if (cmd.msg_clear) len <= '0;
  end

  // Padded message bytes of the first four block words.
  always_comb begin
    for (int j = 0; j < pps_pkg::MSG_BYTES; j++) begin
      if (pps_pkg::LEN_W'(j) < len)       blk[j] = msg[j];
      else if (pps_pkg::LEN_W'(j) == len) blk[j] = pps_pkg::PAD_BYTE;
      else                                blk[j] = 8'h00;
    end
  end

  // One SHA-1 round.
  always_comb begin
    tmp = {ra[26:0], ra[31:27]} + pps_pkg::sha_f(cmd.round, rb, rc, rd) + re
          + pps_pkg::sha_k(cmd.round) + w[0];
    w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // Message schedule and working variables.
  always_ff @(posedge clk) begin
    if (cmd.sha_init) begin
      for (int i = 0; i < 4; i++) begin
        w[i] <= {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      for (int i = 4; i < 15; i++) w[i] <= '0;
      w[15] <= {25'd0, len, 3'd0};
      ra <= pps_pkg::H0;
      rb <= pps_pkg::H1;
      rc <= pps_pkg::H2;
      rd <= pps_pkg::H3;
      re <= pps_pkg::H4;
    end else if (cmd.sha_round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      ra <= tmp;
      rb <= ra;
      rc <= {rb[1:0], rb[31:2]};
      rd <= rc;
      re <= rd;
    end
  end

  // Pending digest waits until it is known whether it ends the run.
  always_ff @(posedge clk) begin
    if (cmd.sha_final) begin
      pend      <= {pps_pkg::H4 + re, pps_pkg::H3 + rd, pps_pkg::H2 + rc,
                    pps_pkg::H1 + rb, pps_pkg::H0 + ra};
      pend_time <= wt[0];
    end
    if (cmd.out_load) begin
      out_data <= {pend_time, pend};
      out_last <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.sha_final)     pend_valid <= 1'b1;
      else if (cmd.out_load) pend_valid <= 1'b0;
      if (cmd.out_load)              out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.fill       = fill;
    stat.delta_ok   = !delta[pps_pkg::TIME_BITS]
                      && delta[pps_pkg::TIME_BITS-1:0] >= min_delta
                      && delta[pps_pkg::TIME_BITS-1:0] <= max_delta;
    stat.dig_last   = (dig_idx == '0);
    stat.pend_valid = pend_valid;
    stat.out_full   = out_valid;
  end

endmodule

`default_nettype wire

// File: rtl/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Controller: walks anchors and partners, sequences text building, the
// SHA-1 rounds and the hand-off of digests to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire pps_pkg::dp_stat_t stat,
  output pps_pkg::dp_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PAIR  = 4'd1;
  localparam logic [3:0] S_LOADF = 4'd2;
  localparam logic [3:0] S_DAB   = 4'd3;
  localparam logic [3:0] S_EMIT  = 4'd4;
  localparam logic [3:0] S_BAR   = 4'd5;
  localparam logic [3:0] S_INIT  = 4'd6;
  localparam logic [3:0] S_ROUND = 4'd7;
  localparam logic [3:0] S_FINAL = 4'd8;
  localparam logic [3:0] S_NEXTA = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]                    state, state_next;
  logic [pps_pkg::IDX_W-1:0]     n, n_next;
  logic [pps_pkg::IDX_W-1:0]     b, b_next;
  logic                          last_r, last_next;
  logic [1:0]                    field, field_next;
  logic [pps_pkg::STEP_W-1:0]    cnt, cnt_next;
  logic [pps_pkg::ROUND_W-1:0]   r, r_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      n      <= '0;
      b      <= '0;
      last_r <= 1'b0;
      field  <= pps_pkg::FIELD_ANCHOR;
      cnt    <= '0;
      r      <= '0;
    end else begin
      state  <= state_next;
      n      <= n_next;
      b      <= b_next;
      last_r <= last_next;
      field  <= field_next;
      cnt    <= cnt_next;
      r      <= r_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    n_next     = n;
    b_next     = b;
    last_next  = last_r;
    field_next = field;
    cnt_next   = cnt;
    r_next     = r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.b_idx  = b;
    cmd.field  = field;
    cmd.round  = r;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          n_next    = stat.fill + 1'b1;
          last_next = in_last;
          b_next    = pps_pkg::IDX_W'(1);
          if (in_last || stat.fill == pps_pkg::IDX_W'(pps_pkg::HOLD)) state_next = S_PAIR;
          else state_next = S_FIN;
        end
      end
      S_PAIR: begin
        if (b == n) begin
          state_next = S_NEXTA;
        end else if (stat.delta_ok) begin
          // An older digest must leave before a new one can be finished.
          if (!(stat.pend_valid && stat.out_full)) begin
            cmd.out_load  = stat.pend_valid;
            cmd.msg_clear = 1'b1;
            field_next    = pps_pkg::FIELD_ANCHOR;
            state_next    = S_LOADF;
          end
        end else begin
          b_next = b + 1'b1;
        end
      end
      S_LOADF: begin
        cmd.bcd_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DAB;
      end
      S_DAB: begin
        cmd.bcd_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == pps_pkg::STEP_W'(pps_pkg::BIN_W - 1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (stat.dig_last) begin
          if (field == pps_pkg::FIELD_DELTA) state_next = S_INIT;
          else state_next = S_BAR;
        end
      end
      S_BAR: begin
        cmd.emit_bar = 1'b1;
        field_next   = field + 1'b1;
        state_next   = S_LOADF;
      end
      S_INIT: begin
        cmd.sha_init = 1'b1;
        r_next       = '0;
        state_next   = S_ROUND;
      end
      S_ROUND: begin
        cmd.sha_round = 1'b1;
        r_next        = r + 1'b1;
        if (r == pps_pkg::ROUND_W'(pps_pkg::ROUNDS - 1)) state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.sha_final = 1'b1;
        b_next        = b + 1'b1;
        state_next    = S_PAIR;
      end
      S_NEXTA: begin
        if (last_r) begin
          // Flush: the next held peak becomes the anchor.
          cmd.shift_win = 1'b1;
          n_next        = n - 1'b1;
          b_next        = pps_pkg::IDX_W'(1);
          if (n == pps_pkg::IDX_W'(1)) state_next = S_FIN;
          else state_next = S_PAIR;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!(stat.pend_valid && stat.out_full)) begin
          cmd.out_load = stat.pend_valid;
          cmd.out_last = 1'b1;
          if (last_r) begin
            cmd.fill_op = pps_pkg::FILL_CLEAR;
          end else if (n == pps_pkg::IDX_W'(pps_pkg::FAN)) begin
            cmd.shift_win = 1'b1;
            cmd.fill_op   = pps_pkg::FILL_HOLD;
          end else begin
            cmd.fill_op = pps_pkg::FILL_INC;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: tb/tb_peak_pair_sha1_hasher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_peak_pair_sha1_hasher
// Streams tracks of spectral peaks into the hasher. A software copy of the
// pairing window and a SHA-1 routine predict every digest word in order, and
// a monitor compares each output word field by field. Phases change the time
// difference bounds and the idle patterns on both streams.
// ----------------------------------------------------------------------------

module tb_peak_pair_sha1_hasher;

  import pps_pkg::*;

  typedef struct {
    logic [11:0] freq;
    logic [15:0] tstamp;
    logic        last;
  } peak_t;

  typedef struct {
    logic [31:0] digest [5];
    logic [15:0] anchor;
    logic        run_end;
  } hash_word_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [175:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_BITS-1:0] cfg_data;

  peak_t      peak_q [$];
  hash_word_t hash_q [$];
  peak_t      next_peak;
  int         peaks_queued;
  int         peaks_taken;
  int         errors;
  int         send_idle;
  int         recv_stall;

  // Predictor copy of the window and the bounds.
  logic [11:0] win_freq [HOLD];
  logic [15:0] win_time [HOLD];
  int          win_fill;
  int          min_delta;
  int          max_delta;

  peak_pair_sha1_hasher u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // SHA-1 of a short message that fits one padded block.
  function automatic logic [159:0] sha1_block(input string text);
    logic [7:0]  blk [64];
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int          len;
    len = text.len();
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < len; i++) blk[i] = text[i];
    blk[len] = 8'h80;
    blk[62]  = 8'((len * 8) >> 8);
    blk[63]  = 8'(len * 8);
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = H0; b = H1; c = H2; d = H3; e = H4;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);          k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;                   k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;                   k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    return {H0 + a, H1 + b, H2 + c, H3 + d, H4 + e};
  endfunction

  // Works out the digests that one accepted peak causes and updates the window.
  task automatic hash_peak(input logic [11:0] fr, input logic [15:0] tm, input logic last);
    logic [11:0]  sf [FAN];
    logic [15:0]  st [FAN];
    int           n, anchors, delta, count;
    hash_word_t   hw;
    logic [159:0] dg;
    count = 0;
    for (int i = 0; i < win_fill; i++) begin
      sf[i] = win_freq[i];
      st[i] = win_time[i];
    end
    sf[win_fill] = fr;
    st[win_fill] = tm;
    n = win_fill + 1;
    anchors = last ? n : ((n == FAN) ? 1 : 0);
    for (int a = 0; a < anchors; a++) begin
      for (int b = a + 1; b < n; b++) begin
        delta = int'(st[b]) - int'(st[a]);
        if (delta >= min_delta && delta <= max_delta) begin
          dg = sha1_block($sformatf("%0d|%0d|%0d", sf[a], sf[b], delta));
          for (int i = 0; i < 5; i++) hw.digest[i] = dg[159 - 32*i -: 32];
          hw.anchor  = st[a];
          hw.run_end = 1'b0;
          hash_q.push_back(hw);
          count++;
        end
      end
    end
    if (count > 0) hash_q[hash_q.size() - 1].run_end = 1'b1;
    if (last) begin
      for (int i = 0; i < HOLD; i++) begin
        win_freq[i] = '0;
        win_time[i] = '0;
      end
      win_fill = 0;
    end else if (win_fill < HOLD) begin
      win_freq[win_fill] = fr;
      win_time[win_fill] = tm;
      win_fill++;
    end else begin
      for (int i = 0; i + 1 < HOLD; i++) begin
        win_freq[i] = win_freq[i+1];
        win_time[i] = win_time[i+1];
      end
      win_freq[HOLD-1] = fr;
      win_time[HOLD-1] = tm;
    end
  endtask

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Driver: feeds peaks from the pending queue and predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        hash_peak(s_axis_tdata[11:0], s_axis_tdata[27:12], s_axis_tlast);
        peaks_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (peak_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          next_peak = peak_q.pop_front();
          s_axis_tdata  <= {4'b0, next_peak.tstamp, next_peak.freq};
          s_axis_tlast  <= next_peak.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted digest word against the oldest prediction.
  always @(posedge clk) begin
    hash_word_t hw;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hash_q.size() == 0) begin
        report("digest word with nothing expected");
      end else begin
        hw = hash_q.pop_front();
        for (int i = 0; i < 5; i++)
          if (m_axis_tdata[32*i +: 32] !== hw.digest[i])
            report($sformatf("digest_w%0d got %h want %h", i,
                             m_axis_tdata[32*i +: 32], hw.digest[i]));
        if (m_axis_tdata[175:160] !== hw.anchor)
          report($sformatf("anchor_time got %0d want %0d", m_axis_tdata[175:160], hw.anchor));
        if (m_axis_tlast !== hw.run_end)
          report($sformatf("run_end got %b want %b", m_axis_tlast, hw.run_end));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic add_peak(input int fr, input int tm, input bit last);
    peak_t p;
    p.freq   = 12'(fr);
    p.tstamp = 16'(tm);
    p.last   = last;
    peak_q.push_back(p);
    peaks_queued++;
  endtask

  // One register write through the configuration channel.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MIN_DELTA) min_delta = value & 16'hFFFF;
    else if (idx == REG_MAX_DELTA) max_delta = value & 16'hFFFF;
  endtask

  // Waits until every peak is taken and every digest has come, then lets
  // the block finish any pair work that produces nothing.
  task automatic drain();
    while (peaks_taken != peaks_queued || hash_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  // A track of random peaks: mostly rising times, a few going backward.
  task automatic random_track(input int len, input int step_max, input int start);
    int tm;
    int fr;
    tm = start;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: fr = 0;
        1: fr = 4095;
        default: fr = $urandom_range(4095);
      endcase
      add_peak(fr, tm, i == len - 1);
      if ($urandom_range(9) == 0) tm = tm - $urandom_range(20);
      else tm = tm + $urandom_range(step_max);
    end
  endtask

  task automatic random_phase(input int items, input int step_max);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 16);
      if ($urandom_range(5) == 0)
        random_track(len, 65535, $urandom_range(65535));
      else
        random_track(len, step_max, $urandom_range(65535));
      sent += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    peaks_queued  = 0;
    peaks_taken   = 0;
    errors        = 0;
    send_idle     = 0;
    recv_stall    = 0;
    min_delta     = 0;
    max_delta     = 200;
    win_fill      = 0;
    for (int i = 0; i < HOLD; i++) begin
      win_freq[i] = '0;
      win_time[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: final peak alone, field extremes, times out of order,
    // a full window that shifts, and the flush.
    add_peak(4095, 65535, 1);
    add_peak(0, 0, 0);
    add_peak(4095, 0, 0);
    add_peak(123, 5, 0);
    add_peak(7, 3, 0);
    add_peak(4095, 65535, 0);
    for (int i = 0; i < 8; i++) add_peak(i * 37 + 1000, 10 + i * 20, 0);
    add_peak(2048, 200, 0);
    add_peak(0, 400, 1);
    add_peak(4095, 65535, 0);
    add_peak(1, 0, 1);
    drain();

    write_reg(REG_MIN_DELTA, 0);
    write_reg(REG_MAX_DELTA, 65535);
    add_peak(4095, 0, 0);
    add_peak(4095, 65535, 1);
    send_idle = 86;
    random_phase(50, 30);
    drain();

    write_reg(REG_MAX_DELTA, 40);
    send_idle = 0;
    recv_stall = 86;
    random_phase(50, 20);
    drain();

    write_reg(REG_MIN_DELTA, 30);
    write_reg(REG_MAX_DELTA, 10);
    send_idle = 11;
    recv_stall = 11;
    random_phase(40, 20);
    drain();

    write_reg(REG_MIN_DELTA, 0);
    write_reg(REG_MAX_DELTA, 0);
    send_idle = 0;
    recv_stall = 0;
    random_phase(50, 2);
    drain();

    write_reg(REG_MIN_DELTA, 65535);
    write_reg(REG_MAX_DELTA, 65535);
    send_idle = 11;
    recv_stall = 11;
    add_peak(9, 0, 0);
    add_peak(4095, 65535, 1);
    random_phase(30, 65535);
    drain();

    write_reg(REG_MIN_DELTA, $urandom_range(20));
    write_reg(REG_MAX_DELTA, $urandom_range(20, 150));
    send_idle = 86;
    recv_stall = 86;
    random_phase(60, 40);
    drain();

    if (hash_q.size() != 0) report("digest words still expected at the end");
    if (errors == 0) begin
      $display("peak_pair_sha1_hasher test passed");
    end else begin
      $display("peak_pair_sha1_hasher test failed");
    end
    $finish;
  end

  // Safety limit on the whole run.
  initial begin
    #40_000_000;
    $display("peak_pair_sha1_hasher test failed");
    $finish;
  end

endmodule
